/* rtl/core/cv3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_pkg - shared types and constants of the 3x3 convolution block
// Sizes, line store word, stage tag and the side length clamp.
// ----------------------------------------------------------------------------
package cv3_pkg;

   localparam int MAX_SIDE = 32;
   localparam int MIN_SIDE = 2;
   localparam int IDX_W    = $clog2(MAX_SIDE);
   localparam int CNT_W    = IDX_W + 1;
   localparam int SIDE_W   = 6;
   localparam int ELEM_W   = 32;
   localparam int VAL_W    = 35;
   localparam int POS_W    = 6;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(32);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [VAL_W-1:0]  value_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [SIDE_W-1:0]        side_type;
   typedef logic [POS_W-1:0]         pos_type;

   // one line store entry: two rows back (upper) and one row back (lower)
   typedef struct packed {
      elem_type upper;
      elem_type lower;
   } ls_word_type;

   // position and border flags of the word held in the input stage
   typedef struct packed {
      logic    emits;      // word produces a result
      logic    up_ok;      // row two above exists
      logic    lo_ok;      // row above exists
      logic    has_right;  // column to the right exists
      logic    first_col;
      logic    flush;      // last-row flush word, no line store write
      logic    run_last;
      logic    done;
      idx_type res_row;
      idx_type col;
   } tag_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
   } mem_port_type;

   typedef struct packed {
      logic free;   // output register can take a word this cycle
      logic empty;  // output register holds nothing
   } rsp_status_type;

   function automatic cnt_type side_in_use(side_type side);
      cnt_type n;
      if (side < SIDE_W'(MIN_SIDE)) begin
         n = CNT_W'(MIN_SIDE);
      end else if (side > SIDE_W'(MAX_SIDE)) begin
         n = CNT_W'(MAX_SIDE);
      end else begin
         n = CNT_W'(side);
      end
      return n;
   endfunction

endpackage

/* rtl/core/cv3_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_line_store - line store memory
// Both previous rows side by side, one write and one registered read port,
// with write-to-read bypass when both hit the same entry.
// ----------------------------------------------------------------------------
module cv3_line_store (
   input  logic                  clock,
   input  logic                  reset,
   input  cv3_pkg::mem_port_type wr_port,
   input  cv3_pkg::ls_word_type  wr_data,
   input  cv3_pkg::mem_port_type rd_port,
   output cv3_pkg::ls_word_type  rd_data
);
   import cv3_pkg::*;

   ls_word_type mem [MAX_SIDE];
   ls_word_type rd_ff;
   ls_word_type byp_data_ff;
   logic        byp_ff;
   logic        byp_in;

   assign byp_in = wr_port.en && (wr_port.addr == rd_port.addr);

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         mem[wr_port.addr] <= wr_data;
      end
      if (rd_port.en) begin
         rd_ff       <= mem[rd_port.addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_port.en) begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

/* rtl/core/cv3_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_seq - position counters, flush sequencer and input stage
// Tracks the raster position, holds the side length register, inserts the
// last-row flush words and drives the line store ports.
// ----------------------------------------------------------------------------
module cv3_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  cv3_pkg::elem_type       req_element,
   output logic                    req_stall,
   input  logic                    csr_valid,
   input  cv3_pkg::side_type       csr_side_length,
   output logic                    csr_ready,
   input  cv3_pkg::rsp_status_type rsp_status,
   output logic                    a_go,
   output cv3_pkg::tag_type        a_tag,
   output cv3_pkg::elem_type       a_elem,
   output cv3_pkg::mem_port_type   rd_port,
   output cv3_pkg::mem_port_type   wr_port
);
   import cv3_pkg::*;

   side_type side_ff;
   idx_type  row_ff;
   idx_type  col_ff;
   logic     flush_ff;
   idx_type  fcol_ff;
   logic     a_vld_ff;
   tag_type  a_tag_ff;
   elem_type a_elem_ff;

   tag_type  tag_in;
   elem_type elem_in;
   idx_type  new_col;
   cnt_type  n_use;
   cnt_type  n_m1;
   logic     col_last;
   logic     row_last;
   logic     final_elem;
   logic     fcol_last;
   logic     a_load;
   logic     req_acc;
   logic     inj;
   logic     load;
   logic     cfg_wr;

   always_comb begin
      n_use      = side_in_use(side_ff);
      n_m1       = n_use - CNT_W'(1);
      col_last   = CNT_W'(col_ff) == n_m1;
      row_last   = CNT_W'(row_ff) == n_m1;
      final_elem = col_last && row_last;
      fcol_last  = CNT_W'(fcol_ff) == n_m1;

      a_go      = a_vld_ff && (rsp_status.free || !a_tag_ff.emits);
      a_load    = !a_vld_ff || a_go;
      // a pending register write holds off new elements
      req_stall = flush_ff || !a_load || csr_valid;
      req_acc   = req_valid && !req_stall;
      inj       = flush_ff && a_load;
      load      = req_acc || inj;
      csr_ready = !a_vld_ff && !flush_ff && rsp_status.empty;
      cfg_wr    = csr_valid && csr_ready;

      new_col = flush_ff ? fcol_ff : col_ff;

      tag_in.has_right = (CNT_W'(new_col) + CNT_W'(1)) < n_use;
      tag_in.first_col = new_col == '0;
      tag_in.col       = new_col;
      if (flush_ff) begin
         // last row: up, upright, left and right neighbours only, nothing below
         tag_in.emits    = 1'b1;
         tag_in.up_ok    = 1'b1;
         tag_in.lo_ok    = 1'b1;
         tag_in.flush    = 1'b1;
         tag_in.run_last = fcol_last;
         tag_in.done     = fcol_last;
         tag_in.res_row  = IDX_W'(n_m1);
         elem_in         = '0;
      end else begin
         tag_in.emits    = row_ff != '0;
         tag_in.up_ok    = row_ff > IDX_W'(1);
         tag_in.lo_ok    = row_ff != '0;
         tag_in.flush    = 1'b0;
         tag_in.run_last = !final_elem;
         tag_in.done     = 1'b0;
         tag_in.res_row  = row_ff - IDX_W'(1);
         elem_in         = req_element;
      end

      // read one column ahead; the current column comes from the window side
      rd_port.en   = load;
      rd_port.addr = new_col + IDX_W'(1);
      wr_port.en   = a_go && !a_tag_ff.flush;
      wr_port.addr = a_tag_ff.col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= SIDE_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         flush_ff <= 1'b0;
         fcol_ff  <= '0;
         a_vld_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            side_ff <= csr_side_length;
            row_ff  <= '0;
            col_ff  <= '0;
         end else if (req_acc) begin
            if (final_elem) begin
               row_ff   <= '0;
               col_ff   <= '0;
               flush_ff <= 1'b1;
               fcol_ff  <= '0;
            end else if (col_last) begin
               col_ff <= '0;
               row_ff <= row_ff + IDX_W'(1);
            end else begin
               col_ff <= col_ff + IDX_W'(1);
            end
         end
         if (inj) begin
            fcol_ff <= fcol_ff + IDX_W'(1);
            if (fcol_last) begin
               flush_ff <= 1'b0;
            end
         end
         if (load) begin
            a_vld_ff <= 1'b1;
         end else if (a_go) begin
            a_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_tag_ff  <= tag_in;
         a_elem_ff <= elem_in;
      end
   end

   assign a_tag  = a_tag_ff;
   assign a_elem = a_elem_ff;

endmodule

/* rtl/core/cv3_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_calc - window, kernel sum and output register
// Keeps the left window column and the current line store word, forms
// up + upright - left - right - downleft + down and holds the result.
// ----------------------------------------------------------------------------
module cv3_calc (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    a_go,
   input  cv3_pkg::tag_type        a_tag,
   input  cv3_pkg::elem_type       a_elem,
   input  cv3_pkg::ls_word_type    rd_data,
   output cv3_pkg::ls_word_type    wr_data,
   input  logic                    rsp_stall,
   output cv3_pkg::rsp_status_type rsp_status,
   output logic                    rsp_valid,
   output cv3_pkg::value_type      rsp_conv_value,
   output cv3_pkg::pos_type        rsp_out_row,
   output cv3_pkg::pos_type        rsp_out_col,
   output logic                    rsp_run_last,
   output logic                    rsp_frame_done
);
   import cv3_pkg::*;

   ls_word_type col0_ff;       // copy of column 0 entry
   ls_word_type prev_next_ff;  // entry read ahead by the previous word
   elem_type    win_lower_ff;  // left neighbour
   elem_type    win_elem_ff;   // down-left neighbour

   logic        b_vld_ff;
   value_type   b_value_ff;
   idx_type     b_row_ff;
   idx_type     b_col_ff;
   logic        b_last_ff;
   logic        b_done_ff;

   ls_word_type word_c;
   elem_type    up;
   elem_type    upright;
   elem_type    left;
   elem_type    right;
   elem_type    dleft;
   value_type   value_in;
   logic        b_load;

   always_comb begin
      word_c  = a_tag.first_col ? col0_ff : prev_next_ff;
      up      = a_tag.up_ok ? word_c.upper : '0;
      upright = (a_tag.up_ok && a_tag.has_right) ? rd_data.upper : '0;
      left    = a_tag.first_col ? '0 : win_lower_ff;
      right   = (a_tag.lo_ok && a_tag.has_right) ? rd_data.lower : '0;
      dleft   = a_tag.first_col ? '0 : win_elem_ff;

      value_in = value_type'(up) + value_type'(upright) - value_type'(left)
               - value_type'(right) - value_type'(dleft) + value_type'(a_elem);

      wr_data.upper = word_c.lower;
      wr_data.lower = a_elem;

      b_load           = a_go && a_tag.emits;
      rsp_status.free  = !b_vld_ff || !rsp_stall;
      rsp_status.empty = !b_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         prev_next_ff <= rd_data;
         win_lower_ff <= word_c.lower;
         win_elem_ff  <= a_elem;
         if (a_tag.first_col && !a_tag.flush) begin
            col0_ff <= wr_data;
         end
      end
      if (b_load) begin
         b_value_ff <= value_in;
         b_row_ff   <= a_tag.res_row;
         b_col_ff   <= a_tag.col;
         b_last_ff  <= a_tag.run_last;
         b_done_ff  <= a_tag.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_load) begin
         b_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         b_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid      = b_vld_ff;
   assign rsp_conv_value = b_value_ff;
   assign rsp_out_row    = POS_W'(b_row_ff);
   assign rsp_out_col    = POS_W'(b_col_ff);
   assign rsp_run_last   = b_last_ff;
   assign rsp_frame_done = b_done_ff;

endmodule

/* rtl/core/conv3x3_zero_padded_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_top - streaming 3x3 convolution with zero borders
// Takes a square matrix in raster order, one signed Q16.16 element per word,
// and returns one full-width result per matrix position.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : element words in raster order; accepted when req_valid is high
//            and req_stall is low.
//   rsp_*  : result words with value, row, column and two end flags;
//            taken when rsp_valid is high and rsp_stall is low.
//   csr_*  : side length write (valid/ready); restarts the frame. Ready
//            only while nothing is in flight; req_stall is held high while
//            csr_valid is up.
// Throughput: one element per cycle while req_stall is low. Element (r, c)
//   releases result (r-1, c); row 0 releases nothing. The final element
//   releases result (side-2, side-1) and then the whole last row: side+1
//   words, during which req_stall stays high while the line store is swept
//   one column per cycle whenever the result register can take a word.
// Path: an accepted element is registered in the input stage, then its
//   result in the result register, where rsp_valid rises.
// Stall: a stalled result holds in the output register; the input stage
//   keeps taking elements that produce no result, otherwise req_stall rises.
// Reset: side length back to 32, position to the start of a frame, both
//   pipeline stages empty. Line store contents are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cv3_pkg::elem_type    req_element,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cv3_pkg::value_type   rsp_conv_value,
   output cv3_pkg::pos_type     rsp_out_row,
   output cv3_pkg::pos_type     rsp_out_col,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_done,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  cv3_pkg::side_type    csr_side_length
);
   import cv3_pkg::*;

   // input stage to kernel stage
   logic           a_go;
   tag_type        a_tag;
   elem_type       a_elem;

   // line store ports
   mem_port_type   rd_port;
   mem_port_type   wr_port;
   ls_word_type    rd_data;
   ls_word_type    wr_data;

   // output register state fed back to the sequencer
   rsp_status_type rsp_status;

   // counters, side register, flush sweep and input stage
   cv3_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_element     (req_element),
      .req_stall       (req_stall),
      .csr_valid       (csr_valid),
      .csr_side_length (csr_side_length),
      .csr_ready       (csr_ready),
      .rsp_status      (rsp_status),
      .a_go            (a_go),
      .a_tag           (a_tag),
      .a_elem          (a_elem),
      .rd_port         (rd_port),
      .wr_port         (wr_port)
   );

   // two previous rows, read one column ahead of the input stage
   cv3_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .wr_port (wr_port),
      .wr_data (wr_data),
      .rd_port (rd_port),
      .rd_data (rd_data)
   );

   // window, kernel sum and result register
   cv3_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .a_go           (a_go),
      .a_tag          (a_tag),
      .a_elem         (a_elem),
      .rd_data        (rd_data),
      .wr_data        (wr_data),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_valid      (rsp_valid),
      .rsp_conv_value (rsp_conv_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

/* sim/conv3x3_zero_padded_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_top_tb - self-checking bench for the 3x3 convolution
// Streams square matrices through the block. A bench-side model of the
// convolution predicts each result word, and a checker compares every word
// taken from the result channel with the oldest prediction. The sender works
// in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_top_tb;
   import cv3_pkg::*;

   localparam int          RANDOM_ITEMS  = 40;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          HOLD_CYCLES   = 200;
   localparam longint      LIMIT_NS      = 5_000_000;
   localparam elem_type    ELEM_MAX      = 32'sh7FFF_FFFF;
   localparam elem_type    ELEM_MIN      = 32'sh8000_0000;

   typedef struct packed {
      value_type value;
      pos_type   row;
      pos_type   col;
      logic      run_last;
      logic      frame_done;
   } conv_result_t;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   elem_type   req_element;
   logic       rsp_valid;
   logic       rsp_stall;
   value_type  rsp_conv_value;
   pos_type    rsp_out_row;
   pos_type    rsp_out_col;
   logic       rsp_run_last;
   logic       rsp_frame_done;
   logic       csr_valid;
   logic       csr_ready;
   side_type   csr_side_length;

   // bench copy of the block state
   elem_type     row_two_back [MAX_SIDE];
   elem_type     row_one_back [MAX_SIDE];
   int unsigned  frame_row;
   int unsigned  frame_col;
   side_type     side_reg;

   conv_result_t expected_results [$];
   int           fail_count;

   // sender bursts and receiver pattern
   int           burst_left;
   int           hold_request;
   int           hold_left;
   int           stall_mode;
   int           pattern_left;
   int           random_items;

   conv3x3_zero_padded_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_conv_value  (rsp_conv_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_side_length (csr_side_length)
   );

   always #5 clock = ~clock;

   // side in use: register value clamped to 2..MAX_SIDE
   function automatic int unsigned side_eff(input side_type s);
      if (s < 2) begin
         return 2;
      end else if (s > MAX_SIDE) begin
         return MAX_SIDE;
      end
      return s;
   endfunction

   function automatic void queue_result(input value_type v, input int unsigned r,
                                        input int unsigned c, input logic last,
                                        input logic done);
      conv_result_t res;
      res.value      = v;
      res.row        = pos_type'(r);
      res.col        = pos_type'(c);
      res.run_last   = last;
      res.frame_done = done;
      expected_results.push_back(res);
   endfunction

   // One element in: result (r-1, c) comes out; the final element of the
   // matrix also sweeps the last row. After an element has been stored,
   // row_two_back[c-1] holds row r-1 and row_one_back[c-1] holds row r,
   // which gives the left and down-left neighbours without a window.
   function automatic void convolve_element(input elem_type e);
      int unsigned n;
      int unsigned r;
      int unsigned c;
      int unsigned j;
      logic        right_ok;
      logic        last_elem;
      value_type   up;
      value_type   upright;
      value_type   left;
      value_type   right;
      value_type   dleft;
      n = side_eff(side_reg);
      if (frame_row >= n || frame_col >= n) begin
         frame_row = 0;
         frame_col = 0;
      end
      r         = frame_row;
      c         = frame_col;
      right_ok  = (c + 1) < n;
      last_elem = (r == n - 1) && (c == n - 1);
      if (r >= 1) begin
         up      = '0;
         upright = '0;
         left    = '0;
         right   = '0;
         dleft   = '0;
         if (r >= 2) begin
            up = row_two_back[c];
            if (right_ok) begin
               upright = row_two_back[c+1];
            end
         end
         if (c >= 1) begin
            left  = row_two_back[c-1];
            dleft = row_one_back[c-1];
         end
         if (right_ok) begin
            right = row_one_back[c+1];
         end
         queue_result(up + upright - left - right - dleft + e, r - 1, c, !last_elem, 1'b0);
      end
      row_two_back[c] = row_one_back[c];
      row_one_back[c] = e;
      if (last_elem) begin
         for (j = 0; j < n; j++) begin
            up      = row_two_back[j];
            upright = '0;
            left    = '0;
            right   = '0;
            if (j + 1 < n) begin
               upright = row_two_back[j+1];
               right   = row_one_back[j+1];
            end
            if (j >= 1) begin
               left = row_one_back[j-1];
            end
            queue_result(up + upright - left - right, n - 1, j, j == n - 1, j == n - 1);
         end
         frame_row = 0;
         frame_col = 0;
      end else if (c == n - 1) begin
         frame_col = 0;
         frame_row = r + 1;
      end else begin
         frame_col = c + 1;
      end
   endfunction

   function automatic elem_type pick_element();
      case ($urandom_range(0, 7))
         0:       return ELEM_MAX;
         1:       return ELEM_MIN;
         2:       return '0;
         3:       return '1;
         4:       return elem_type'(int'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
         default: return elem_type'($urandom);
      endcase
   endfunction

   // one element word: optional gap at the start of a burst, then wait for
   // acceptance and predict
   task automatic send_element(input elem_type e);
      int gap;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_element <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      convolve_element(e);
   endtask

   task automatic send_random_elements(input int count);
      repeat (count) send_element(pick_element());
   endtask

   // sender pauses until every predicted word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // row 0 words leave nothing to wait for but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input side_type s);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_side_length <= s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      side_reg  = s;
      frame_row = 0;
      frame_col = 0;
   endtask

   // side 3: centre result at the largest and then the smallest sum
   task automatic test_extreme_sums();
      write_side(side_type'(3));
      send_element('0);
      send_element(ELEM_MAX);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element(32'sh0001_0000);
      send_element(ELEM_MIN);
      send_element(ELEM_MIN);
      send_element(ELEM_MAX);
      send_element('1);
      // second matrix follows straight on, no register write
      send_element(32'sh0000_8000);
      send_element(ELEM_MIN);
      send_element(ELEM_MIN);
      send_element(ELEM_MAX);
      send_element(32'shFFFF_0000);
      send_element(ELEM_MAX);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element('0);
   endtask

   // side 0 clamps up to the smallest matrix
   task automatic test_side_clamp();
      write_side(side_type'(0));
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element('1);
      send_element(32'sh0000_8000);
   endtask

   // long receiver hold-off while the sender keeps offering words
   task automatic test_backpressure();
      write_side(side_type'(5));
      hold_request = HOLD_CYCLES;
      send_random_elements(30);
      wait_drained();
      send_random_elements(10);
   endtask

   // first rows of the largest matrix, reached through a register value
   // above the clamp
   task automatic test_full_side();
      write_side(side_type'(63));
      send_random_elements(2 * MAX_SIDE + 4);
   endtask

   // mostly small matrices, some cut short by a register write
   task automatic test_random_frames();
      side_type    s;
      int unsigned n;
      int          count;
      logic        complete;
      complete = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         if (!complete || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0:       s = side_type'(0);
               1:       s = side_type'(1);
               9:       s = side_type'($urandom_range(32, 63));
               default: s = side_type'($urandom_range(2, 8));
            endcase
            write_side(s);
         end
         n     = side_eff(side_reg);
         count = n * n;
         if (n == MAX_SIDE) begin
            count = $urandom_range(1, MAX_SIDE + 8);
         end else if ($urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, n * n - 1);
         end
         complete = (count == n * n);
         send_random_elements(count);
         random_items += count;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      conv_result_t got;
      conv_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.value      = rsp_conv_value;
         got.row        = rsp_out_row;
         got.col        = rsp_out_col;
         got.run_last   = rsp_run_last;
         got.frame_done = rsp_frame_done;
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected word: value %0d row %0d col %0d last %0b done %0b",
                        got.value, got.row, got.col, got.run_last, got.frame_done);
            end
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: exp value %0d row %0d col %0d last %0b done %0b",
                           want.value, want.row, want.col, want.run_last,
                           want.frame_done);
                  $display("          got value %0d row %0d col %0d last %0b done %0b",
                           got.value, got.row, got.col, got.run_last, got.frame_done);
               end
            end
         end
      end
   end

   // receiver: own stall pattern, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (pattern_left <= 0) begin
         stall_mode   = $urandom_range(0, 3);
         pattern_left = $urandom_range(8, 48);
      end else begin
         pattern_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 9) < 3);
            2:       rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= pattern_left[0];
         endcase
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int wait_cycles;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_element     = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_side_length = '0;
      side_reg        = SIDE_RESET;
      frame_row       = 0;
      frame_col       = 0;
      fail_count      = 0;
      burst_left      = 0;
      hold_request    = 0;
      hold_left       = 0;
      stall_mode      = 0;
      pattern_left    = 0;
      random_items    = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_sums();
      test_side_clamp();
      test_backpressure();
      test_full_side();
      test_random_frames();

      req_valid   <= 1'b0;
      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d predicted words never arrived", expected_results.size());
         fail_count += expected_results.size();
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/cv3_pkg.sv
rtl/core/cv3_line_store.sv
rtl/core/cv3_seq.sv
rtl/core/cv3_calc.sv
rtl/core/conv3x3_zero_padded_top.sv
sim/conv3x3_zero_padded_top_tb.sv
